FILE: rtl/ubxfp_pkg.sv
// ----------------------------------------------------------------------------
// UBX frame parser package
// Shared types and constants for the UBX frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ubxfp_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'hB5;
	localparam logic [7:0] SYNC_SECOND = 8'h62;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_CLASS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_ID_A  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_ID_B  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_ID_C  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD  = 3'd4;

	localparam logic [1:0] MSG_IDX_A = 2'd0;
	localparam logic [1:0] MSG_IDX_B = 2'd1;
	localparam logic [1:0] MSG_IDX_C = 2'd2;

	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_GOOD     = 2'd1,
		KIND_BAD      = 2'd2,
		KIND_TOO_LONG = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0]  accept_class;
		logic [7:0]  accept_id_a;
		logic [7:0]  accept_id_b;
		logic [7:0]  accept_id_c;
		logic [15:0] max_payload;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic [15:0] payload_offset;
		logic [1:0]  message_index;
		logic [15:0] payload_length;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/ubx_frame_parser_core.sv
// ----------------------------------------------------------------------------
// UBX frame parser core
// Sync hunt, class/id filter, length decode, payload emit and Fletcher-8 check.
// ----------------------------------------------------------------------------
//  channel   signals                          transfer when
//  input     in_valid, in_stall, rx_byte      in_valid && !in_stall
//  output    out_valid, out_stall, out_*      out_valid && !out_stall
//  config    cfg_valid, cfg_ready, index/data cfg_valid && cfg_ready
//
//  One byte per cycle while in_stall is low; each byte is parsed combinationally into a result.
//  The result is registered in the result register, or in the skid entry while that register is stalled.
//  A skid entry behind the result register holds one result under output stall;
//  in_stall rises only while that entry is occupied.
//  Reset clears the parser to sync hunt and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module ubx_frame_parser_core
	import ubxfp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            rx_byte,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [1:0]                 out_kind,
	output logic [7:0]                 payload_byte,
	output logic [15:0]                payload_offset,
	output logic [1:0]                 message_index,
	output logic [15:0]                payload_length,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg;
	result_t res;
	result_t out_res;
	logic    res_valid;
	logic    byte_fire;
	logic    buf_full;

	assign cfg_ready = 1'b1;
	assign in_stall  = buf_full;
	assign byte_fire = in_valid && !buf_full;

	ubxfp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ubxfp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_fire (byte_fire),
		.rx_byte   (rx_byte),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	ubxfp_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (byte_fire && res_valid),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_res   (out_res),
		.full      (buf_full)
	);

	assign out_kind       = out_res.kind;
	assign payload_byte   = out_res.payload_byte;
	assign payload_offset = out_res.payload_offset;
	assign message_index  = out_res.message_index;
	assign payload_length = out_res.payload_length;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		buf_full |-> out_valid)
		else $error("skid entry occupied with empty output register");

	a_non_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_kind != KIND_PAYLOAD)) |-> ((payload_byte == 8'd0) &&
			(payload_offset == 16'd0)))
		else $error("non-payload result carries payload fields");

	a_offset_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_kind == KIND_PAYLOAD)) |-> (payload_offset < payload_length))
		else $error("payload offset beyond declared length");

	a_index_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (message_index != 2'd3))
		else $error("message index out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(buf_full && out_stall) |=> buf_full)
		else $error("skid entry lost while output stalled");

endmodule

`default_nettype wire

FILE: rtl/ubxfp_cfg.sv
// ----------------------------------------------------------------------------
// UBX frame parser configuration registers
// Holds class, id and length limit registers written over the config channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ubxfp_cfg
	import ubxfp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accept_class <= 8'd1;
			cfg_q.accept_id_a  <= 8'd2;
			cfg_q.accept_id_b  <= 8'd3;
			cfg_q.accept_id_c  <= 8'd18;
			cfg_q.max_payload  <= 16'd96;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ACCEPT_CLASS: cfg_q.accept_class <= cfg_data[7:0];
				REG_ACCEPT_ID_A:  cfg_q.accept_id_a  <= cfg_data[7:0];
				REG_ACCEPT_ID_B:  cfg_q.accept_id_b  <= cfg_data[7:0];
				REG_ACCEPT_ID_C:  cfg_q.accept_id_c  <= cfg_data[7:0];
				REG_MAX_PAYLOAD:  cfg_q.max_payload  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/ubxfp_parse.sv
// ----------------------------------------------------------------------------
// UBX frame parser state machine
// Tracks frame phase and Fletcher-8 sums; forms one result per byte at most.
// ----------------------------------------------------------------------------
`default_nettype none

module ubxfp_parse
	import ubxfp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_fire,
	input  wire logic [7:0] rx_byte,
	input  wire cfg_t       cfg,
	output logic            res_valid,
	output result_t         res
);

	typedef enum logic [3:0] {
		PH_SYNC1   = 4'd0,
		PH_SYNC2   = 4'd1,
		PH_CLASS   = 4'd2,
		PH_ID      = 4'd3,
		PH_LEN_LO  = 4'd4,
		PH_LEN_HI  = 4'd5,
		PH_PAYLOAD = 4'd6,
		PH_CK_A    = 4'd7,
		PH_CK_B    = 4'd8
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  sum_a_q, sum_a_d, sum_a_add;
	logic [7:0]  sum_b_q, sum_b_d, sum_b_add;
	logic [15:0] len_q, len_d;
	logic [15:0] cnt_q, cnt_d;
	logic [1:0]  match_q, match_d;
	logic        ck_ok_q, ck_ok_d;
	phase_t      reject_phase;

	assign sum_a_add    = sum_a_q + rx_byte;
	assign sum_b_add    = sum_b_q + sum_a_add;
	assign reject_phase = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;

	always_comb begin
		phase_d   = phase_q;
		sum_a_d   = sum_a_q;
		sum_b_d   = sum_b_q;
		len_d     = len_q;
		cnt_d     = cnt_q;
		match_d   = match_q;
		ck_ok_d   = ck_ok_q;
		res_valid = 1'b0;
		res       = '0;
		case (phase_q)
			PH_SYNC1: begin
				phase_d = reject_phase;
			end
			PH_SYNC2: begin
				phase_d = (rx_byte == SYNC_SECOND) ? PH_CLASS : reject_phase;
			end
			PH_CLASS: begin
				if (rx_byte == cfg.accept_class) begin
					sum_a_d = rx_byte;
					sum_b_d = rx_byte;
					phase_d = PH_ID;
				end else begin
					phase_d = reject_phase;
				end
			end
			PH_ID: begin
				phase_d = PH_LEN_LO;
				sum_a_d = sum_a_add;
				sum_b_d = sum_b_add;
				if (rx_byte == cfg.accept_id_a) begin
					match_d = MSG_IDX_A;
				end else if (rx_byte == cfg.accept_id_b) begin
					match_d = MSG_IDX_B;
				end else if (rx_byte == cfg.accept_id_c) begin
					match_d = MSG_IDX_C;
				end else begin
					phase_d = reject_phase;
					sum_a_d = sum_a_q;
					sum_b_d = sum_b_q;
				end
			end
			PH_LEN_LO: begin
				sum_a_d = sum_a_add;
				sum_b_d = sum_b_add;
				len_d   = {8'h00, rx_byte};
				phase_d = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				sum_a_d = sum_a_add;
				sum_b_d = sum_b_add;
				len_d   = {rx_byte, len_q[7:0]};
				cnt_d   = '0;
				if (len_d > cfg.max_payload) begin
					res_valid = 1'b1;
					res.kind  = KIND_TOO_LONG;
					phase_d   = PH_SYNC1;
				end else begin
					phase_d = (len_d == 16'd0) ? PH_CK_A : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				sum_a_d            = sum_a_add;
				sum_b_d            = sum_b_add;
				res_valid          = 1'b1;
				res.kind           = KIND_PAYLOAD;
				res.payload_byte   = rx_byte;
				res.payload_offset = cnt_q;
				cnt_d              = cnt_q + 16'd1;
				if (({1'b0, cnt_q} + 17'd1) >= {1'b0, len_q}) begin
					phase_d = PH_CK_A;
				end
			end
			PH_CK_A: begin
				ck_ok_d = (rx_byte == sum_a_q);
				phase_d = PH_CK_B;
			end
			PH_CK_B: begin
				res_valid = 1'b1;
				res.kind  = (ck_ok_q && (rx_byte == sum_b_q)) ? KIND_GOOD : KIND_BAD;
				phase_d   = PH_SYNC1;
			end
			default: begin
				phase_d = reject_phase;
			end
		endcase
		res.message_index  = match_d;
		res.payload_length = len_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC1;
			sum_a_q <= '0;
			sum_b_q <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
			match_q <= '0;
			ck_ok_q <= 1'b0;
		end else if (byte_fire) begin
			phase_q <= phase_d;
			sum_a_q <= sum_a_d;
			sum_b_q <= sum_b_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			match_q <= match_d;
			ck_ok_q <= ck_ok_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/ubxfp_outbuf.sv
// ----------------------------------------------------------------------------
// UBX frame parser output buffer
// Result register with a skid entry that takes one more result under a stall.
// ----------------------------------------------------------------------------
`default_nettype none

module ubxfp_outbuf
	import ubxfp_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    res_valid,
	input  wire result_t res,
	input  wire logic    out_stall,
	output logic         out_valid,
	output result_t      out_res,
	output logic         full
);

	logic    out_v_q;
	logic    skid_v_q;
	result_t out_q;
	result_t skid_q;
	logic    out_fire;

	assign out_fire = out_v_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_fire) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || out_fire) begin
			out_v_q <= res_valid;
		end else if (res_valid) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_fire) begin
				out_q <= skid_q;
			end
		end else if (!out_v_q || out_fire) begin
			out_q <= res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_v_q;
	assign out_res   = out_q;
	assign full      = skid_v_q;

endmodule

`default_nettype wire
